FILE: hdl/earliest_free_server_assigner_top_assert.svh
// assertion macros for the earliest free server assigner rtl
`ifndef EARLIEST_FREE_SERVER_ASSIGNER_TOP_ASSERT_SVH
`define EARLIEST_FREE_SERVER_ASSIGNER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EFSA_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("efsa assertion failed");
// next-cycle implication
`define EFSA_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("efsa assertion failed");
`else
`define EFSA_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define EFSA_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

FILE: hdl/efsa_pkg.sv
// shared constants and control types for the earliest free server assigner
package efsa_pkg;

  localparam int SERVERS = 16;
  localparam int IDX_W   = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CNT_W   = $clog2(SERVERS + 1);

  localparam int DUR_W = 16;
  localparam int JOB_W = 20;
  localparam int SUM_W = 40;
  localparam int SRV_W = 4;
  localparam int CFG_W = 5;

  localparam logic [JOB_W-1:0] JOB_MAX   = {JOB_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

  // input word operations
  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic start_arr;
    logic start_flush;
    logic step;
    logic commit;
    logic emit;
    logic clear;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_last;
    logic need_out;
    logic any_best;
    logic can_load;
  } sts_t;

endpackage

FILE: hdl/efsa_in_if.sv
// job input channel
interface efsa_in_if;
  import efsa_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [DUR_W-1:0] duration;

  modport source (output valid, output op, output duration, input ready);
  modport sink   (input valid, input op, input duration, output ready);
endinterface

FILE: hdl/efsa_out_if.sv
// departing job result channel
interface efsa_out_if;
  import efsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [JOB_W-1:0] job_number;
  logic [SRV_W-1:0] server_index;
  logic [SUM_W-1:0] total_duration;
  logic             last;

  modport source (output valid, output job_number, output server_index,
                  output total_duration, output last, input ready);
  modport sink   (input valid, input job_number, input server_index,
                  input total_duration, input last, output ready);
endinterface

FILE: hdl/efsa_cfg_if.sv
// configuration write channel for the active server count
interface efsa_cfg_if;
  import efsa_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/efsa_datapath.sv
// server table, scan unit, counters and output register
module efsa_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  efsa_pkg::cmd_t              cmd,
  output efsa_pkg::sts_t              sts,
  input  logic                        cfg_we,
  input  logic [efsa_pkg::CFG_W-1:0]  cfg_data,
  input  logic [efsa_pkg::DUR_W-1:0]  in_duration,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [efsa_pkg::JOB_W-1:0]  out_job_number,
  output logic [efsa_pkg::SRV_W-1:0]  out_server_index,
  output logic [efsa_pkg::SUM_W-1:0]  out_total_duration,
  output logic                        out_last
);
  import efsa_pkg::*;

  logic [DUR_W-1:0]   rt_r  [SERVERS];
  logic [JOB_W-1:0]   own_r [SERVERS];
  logic [SERVERS-1:0] occ_r;

  logic [CFG_W-1:0] cfg_r;
  logic [JOB_W-1:0] next_job_r, next_job_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [DUR_W-1:0] dur_r;
  logic [JOB_W-1:0] job_r;

  logic [CNT_W-1:0] idx_r;
  logic [IDX_W-1:0] best_idx_r, empty_idx_r;
  logic [DUR_W-1:0] best_val_r;
  logic             best_vld_r, empty_vld_r, flush_r;

  logic             out_valid_r, out_valid_nxt;
  logic [JOB_W-1:0] out_job_r;
  logic [SRV_W-1:0] out_srv_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_last_r;

  logic [7:0]       cfg_ext;
  logic [CNT_W-1:0] n_act, limit;
  logic [IDX_W-1:0] cur;
  logic [DUR_W-1:0] cur_rt;
  logic             cur_occ, take, can_load, load_arr, load_flush;
  logic [SUM_W:0]   sum_wide;

  // clamp the configured count into 1..SERVERS
  always_comb begin
    cfg_ext = 8'(cfg_r);
    if (cfg_ext == 8'd0) begin
      n_act = CNT_W'(1);
    end else if (cfg_ext > 8'(SERVERS)) begin
      n_act = CNT_W'(SERVERS);
    end else begin
      n_act = CNT_W'(cfg_ext);
    end
  end

  assign limit   = flush_r ? CNT_W'(SERVERS) : n_act;
  assign cur     = idx_r[IDX_W-1:0];
  assign cur_rt  = rt_r[cur];
  assign cur_occ = occ_r[cur];
  // a flush only ranks held jobs
  assign take    = flush_r ? cur_occ : 1'b1;

  assign can_load   = !out_valid_r || out_ready;
  assign load_arr   = cmd.commit && !empty_vld_r;
  assign load_flush = cmd.emit;

  assign sts.scan_last = (idx_r == limit - CNT_W'(1));
  assign sts.need_out  = !empty_vld_r;
  assign sts.any_best  = best_vld_r;
  assign sts.can_load  = can_load;

  assign sum_wide     = {1'b0, sum_r} + (SUM_W + 1)'(in_duration);
  assign sum_nxt      = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
  assign next_job_nxt = (next_job_r == JOB_MAX) ? JOB_W'(1) : next_job_r + JOB_W'(1);

  // control and server state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      occ_r       <= '0;
      next_job_r  <= JOB_W'(1);
      sum_r       <= '0;
      idx_r       <= '0;
      best_vld_r  <= 1'b0;
      empty_vld_r <= 1'b0;
      flush_r     <= 1'b0;
      for (int k = 0; k < SERVERS; k++) begin
        rt_r[k] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      if (cmd.start_arr) begin
        next_job_r <= next_job_nxt;
        sum_r      <= sum_nxt;
      end
      if (cmd.start_arr || cmd.start_flush || cmd.emit) begin
        idx_r       <= '0;
        best_vld_r  <= 1'b0;
        empty_vld_r <= 1'b0;
      end
      if (cmd.start_arr || cmd.start_flush) begin
        flush_r <= cmd.start_flush;
      end
      if (cmd.step) begin
        idx_r <= idx_r + CNT_W'(1);
        if (!flush_r && !cur_occ && !empty_vld_r) begin
          empty_vld_r <= 1'b1;
        end
        if (take && (!best_vld_r || cur_rt < best_val_r)) begin
          best_vld_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        if (empty_vld_r) begin
          occ_r[empty_idx_r] <= 1'b1;
          rt_r[empty_idx_r]  <= dur_r;
        end else begin
          for (int k = 0; k < SERVERS; k++) begin
            if (IDX_W'(k) == best_idx_r) begin
              rt_r[k] <= dur_r;
            end else if (CNT_W'(k) < n_act) begin
              rt_r[k] <= rt_r[k] - best_val_r;
            end
          end
        end
      end
      if (cmd.emit) begin
        occ_r[best_idx_r] <= 1'b0;
      end
      if (cmd.clear) begin
        occ_r      <= '0;
        next_job_r <= JOB_W'(1);
        sum_r      <= '0;
        for (int k = 0; k < SERVERS; k++) begin
          rt_r[k] <= '0;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.start_arr) begin
      dur_r <= in_duration;
      job_r <= next_job_r;
    end
    if (cmd.step) begin
      if (!flush_r && !cur_occ && !empty_vld_r) begin
        empty_idx_r <= cur;
      end
      if (take && (!best_vld_r || cur_rt < best_val_r)) begin
        best_idx_r <= cur;
        best_val_r <= cur_rt;
      end
    end
    if (cmd.commit) begin
      if (empty_vld_r) begin
        own_r[empty_idx_r] <= job_r;
      end else begin
        own_r[best_idx_r] <= job_r;
      end
    end
    if (load_arr || load_flush) begin
      out_job_r <= own_r[best_idx_r];
      out_srv_r <= SRV_W'(best_idx_r);
      out_sum_r <= sum_r;
      // last word of a flush: nothing held besides the one leaving
      out_last_r <= load_flush &&
                    ((occ_r & ~(SERVERS'(1) << best_idx_r)) == '0);
    end
  end

  always_comb begin
    if (load_arr || load_flush) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_job_number     = out_job_r;
  assign out_server_index   = out_srv_r;
  assign out_total_duration = out_sum_r;
  assign out_last           = out_last_r;

endmodule

FILE: hdl/efsa_ctrl.sv
// sequencing state machine for arrivals and flushes
`include "earliest_free_server_assigner_top_assert.svh"

module efsa_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_op,
  output logic           in_ready,
  input  efsa_pkg::sts_t sts,
  output efsa_pkg::cmd_t cmd
);
  import efsa_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ASCAN = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_FSCAN = 3'd3;
  localparam logic [2:0] S_FEMIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_FLUSH) begin
            cmd.start_flush = 1'b1;
            state_nxt       = S_FSCAN;
          end else begin
            cmd.start_arr = 1'b1;
            state_nxt     = S_ASCAN;
          end
        end
      end
      S_ASCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        // a departing job needs room in the output register
        if (!sts.need_out || sts.can_load) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FSCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_FEMIT;
        end
      end
      S_FEMIT: begin
        if (!sts.any_best) begin
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.can_load) begin
          cmd.emit  = 1'b1;
          state_nxt = S_FSCAN;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `EFSA_ASSERT_IMP(a_emit_room, clk, rst_n, cmd.emit, sts.can_load)
  `EFSA_ASSERT_IMP(a_commit_room, clk, rst_n, cmd.commit && sts.need_out, sts.can_load)
  `EFSA_ASSERT_NXT(a_accept_busy, clk, rst_n, rst_n && in_valid && in_ready, state_r != S_IDLE)
  `EFSA_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule

FILE: hdl/earliest_free_server_assigner_top.sv
// top level of the earliest free server assigner
//
//   channel  dir  width        carries
//   in_ch    in   1 + 16       op, duration
//   out_ch   out  20+4+40+1    job_number, server_index, total_duration, last
//   cfg_ch   in   5            servers_in_use
//
// an arrival scans n servers, n the active server count, one scan cycle per server, then commits
// a flush makes one full scan of the server table per departing word and a last
// scan that finds no job held
// no clearing pass after reset; the block takes words as soon as reset drops
// a full output register holds the controller in its commit or emit step
module earliest_free_server_assigner_top (
  input logic        clk,
  input logic        rst_n,
  efsa_in_if.sink    in_ch,
  efsa_out_if.source out_ch,
  efsa_cfg_if.sink   cfg_ch
);
  import efsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  efsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  efsa_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_ch.valid),
    .cfg_data           (cfg_ch.data),
    .in_duration        (in_ch.duration),
    .out_ready          (out_ch.ready),
    .out_valid          (out_ch.valid),
    .out_job_number     (out_ch.job_number),
    .out_server_index   (out_ch.server_index),
    .out_total_duration (out_ch.total_duration),
    .out_last           (out_ch.last)
  );

endmodule

FILE: bench/testbench.sv
// testbench for the earliest free server assigner: directed and random jobs, scoreboard check
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import efsa_pkg::*;

  localparam int   SETTLE    = 3 * SERVERS + 8;
  localparam int   LIMIT     = 1_000_000;
  localparam int   RANDOM_WORDS = 200;

  typedef struct {
    logic [JOB_W-1:0] job;
    logic [SRV_W-1:0] srv;
    logic [SUM_W-1:0] sum;
    logic             last;
  } departure_t;

  logic clk;
  logic rst_n;
  int unsigned cycle_count;
  int unsigned bad_words;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // schedule mirror
  logic [DUR_W-1:0] srv_left [SERVERS];
  logic [JOB_W-1:0] srv_job [SERVERS];
  bit               srv_busy [SERVERS];
  logic [JOB_W-1:0] job_next;
  logic [SUM_W-1:0] dur_total;
  logic [CFG_W-1:0] active_cfg;
  departure_t       departures_due [$];

  efsa_in_if  in_bus ();
  efsa_out_if out_bus ();
  efsa_cfg_if cfg_bus ();

  earliest_free_server_assigner_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int unsigned active_servers();
    if (active_cfg == 0) return 1;
    if (active_cfg > SERVERS) return SERVERS;
    return 32'(active_cfg);
  endfunction

  task automatic clear_schedule();
    for (int i = 0; i < SERVERS; i++) begin
      srv_left[i] = '0;
      srv_job[i]  = '0;
      srv_busy[i] = 1'b0;
    end
    job_next  = JOB_W'(1);
    dur_total = '0;
  endtask

  task automatic predict_departures(input logic op, input logic [DUR_W-1:0] dur);
    departure_t       d;
    bit               taken [SERVERS];
    int unsigned      held, pick, best, n;
    int               empty;
    logic [SUM_W:0]   wide;
    logic [DUR_W-1:0] least;
    logic [JOB_W-1:0] job_id;
    if (op == OP_FLUSH) begin
      held = 0;
      for (int i = 0; i < SERVERS; i++) begin
        taken[i] = 1'b0;
        if (srv_busy[i]) held++;
      end
      // held jobs leave by remaining time, then by server index
      for (int k = 0; k < held; k++) begin
        pick = SERVERS;
        for (int i = 0; i < SERVERS; i++)
          if (srv_busy[i] && !taken[i] && (pick == SERVERS || srv_left[i] < srv_left[pick]))
            pick = i;
        taken[pick] = 1'b1;
        d.job  = srv_job[pick];
        d.srv  = pick[SRV_W-1:0];
        d.sum  = dur_total;
        d.last = (k == held - 1);
        departures_due.push_back(d);
      end
      clear_schedule();
    end else begin
      wide = {1'b0, dur_total} + dur;
      dur_total = wide[SUM_W] ? SUM_MAX : wide[SUM_W-1:0];
      job_id = job_next;
      job_next = (job_next == JOB_MAX) ? JOB_W'(1) : job_next + JOB_W'(1);
      n = active_servers();
      empty = -1;
      for (int i = 0; i < n; i++)
        if (!srv_busy[i] && empty < 0) empty = i;
      if (empty >= 0) begin
        srv_busy[empty] = 1'b1;
        srv_job[empty]  = job_id;
        srv_left[empty] = dur;
      end else begin
        best = 0;
        for (int i = 1; i < n; i++)
          if (srv_left[i] < srv_left[best]) best = i;
        least = srv_left[best];
        // servers beyond the active count keep their time
        for (int i = 0; i < n; i++) srv_left[i] = srv_left[i] - least;
        d.job  = srv_job[best];
        d.srv  = best[SRV_W-1:0];
        d.sum  = dur_total;
        d.last = 1'b0;
        departures_due.push_back(d);
        srv_job[best]  = job_id;
        srv_left[best] = dur;
      end
    end
  endtask

  // result checker and receiver stalls
  initial begin
    departure_t d;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (departures_due.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("unexpected word: job %0d srv %0d sum %0d last %0d",
                     out_bus.job_number, out_bus.server_index,
                     out_bus.total_duration, out_bus.last);
        end else begin
          d = departures_due.pop_front();
          if (out_bus.job_number !== d.job || out_bus.server_index !== d.srv ||
              out_bus.total_duration !== d.sum || out_bus.last !== d.last) begin
            bad_words++;
            if (bad_words <= 10)
              $display("word mismatch: exp job %0d srv %0d sum %0d last %0d, got %0d %0d %0d %0d",
                       d.job, d.srv, d.sum, d.last, out_bus.job_number,
                       out_bus.server_index, out_bus.total_duration, out_bus.last);
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic send_word(input logic op, input logic [DUR_W-1:0] dur);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_bus.valid    <= 1'b1;
    in_bus.op       <= op;
    in_bus.duration <= dur;
    do @(posedge clk); while (!in_bus.ready);
    predict_departures(op, dur);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (departures_due.size() != 0) @(posedge clk);
    // a fill arrival or an empty flush may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_active_count(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    active_cfg = value;
  endtask

  function automatic logic [DUR_W-1:0] pick_duration(input int unsigned style);
    case (style)
      0: return DUR_W'($urandom_range(0, 3));
      1: return DUR_W'($urandom_range(0, 65535));
      default: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return '1;
          default: return DUR_W'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  task automatic test_empty_flush();
    set_idling(0, 0);
    send_word(OP_FLUSH, '1);
    send_word(OP_FLUSH, '0);
  endtask

  task automatic test_single_server();
    write_active_count(CFG_W'(0));
    send_word(OP_ARRIVE, 16'hffff);
    send_word(OP_ARRIVE, 16'h0000);
    send_word(OP_ARRIVE, 16'd7);
    send_word(OP_ARRIVE, 16'hffff);
    send_word(OP_FLUSH, 16'h0000);
  endtask

  task automatic test_equal_times();
    write_active_count(CFG_W'(3));
    repeat (5) send_word(OP_ARRIVE, 16'd4);
    send_word(OP_ARRIVE, 16'd0);
    send_word(OP_FLUSH, 16'd4);
  endtask

  task automatic test_shrunk_set();
    write_active_count(CFG_W'(4));
    send_word(OP_ARRIVE, 16'd9);
    send_word(OP_ARRIVE, 16'd1);
    send_word(OP_ARRIVE, 16'd3);
    send_word(OP_ARRIVE, 16'd2);
    // servers 2 and 3 keep their jobs but drop out of the active set
    write_active_count(CFG_W'(2));
    send_word(OP_ARRIVE, 16'd5);
    send_word(OP_ARRIVE, 16'd5);
    send_word(OP_FLUSH, 16'd0);
  endtask

  task automatic test_random_traffic();
    logic [CFG_W-1:0] extremes [5];
    int unsigned      sent, round, style, n, count;
    extremes = '{CFG_W'(1), CFG_W'(16), CFG_W'(31), CFG_W'(17), CFG_W'(0)};
    sent  = 0;
    round = 0;
    while (sent < RANDOM_WORDS) begin
      case ((round / 2) % 4)
        0: set_idling(0, 0);
        1: set_idling(77, 0);
        2: set_idling(0, 77);
        default: set_idling(13, 13);
      endcase
      write_active_count(round < 5 ? extremes[round] : CFG_W'($urandom_range(0, 31)));
      n = active_servers();
      style = $urandom_range(0, 2);
      if ($urandom_range(0, 9) < 8) begin
        // fill and possibly run past the fill, then flush
        count = $urandom_range(0, 2 * n + 4);
        repeat (count) send_word(OP_ARRIVE, pick_duration(style));
        send_word(OP_FLUSH, DUR_W'($urandom));
        sent += count + 1;
      end else begin
        // loose mix; whatever is left held carries into the next setting
        count = $urandom_range(1, 10);
        repeat (count)
          send_word(($urandom_range(0, 9) < 3) ? OP_FLUSH : OP_ARRIVE, pick_duration(style));
        sent += count;
      end
      round++;
    end
  endtask

  initial begin
    bad_words = 0;
    set_idling(0, 0);
    active_cfg = CFG_RESET;
    clear_schedule();
    rst_n          = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.op       = OP_ARRIVE;
    in_bus.duration = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.data    = CFG_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_flush();
    test_single_server();
    test_equal_times();
    test_shrunk_set();
    test_random_traffic();

    wait_drained();
    if (bad_words == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
